>>> rtl/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types, constants and the sine series for the speed integrator and
// steering angle block.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int FRAC_BITS_DEF  = 12;
  localparam int ASIN_DEPTH_DEF = 256;

  localparam int SPEED_W     = 16;
  localparam int GAIN_W      = 12;
  localparam int LIMIT_W     = 12;
  localparam int WBASE_W     = 15;
  localparam int DRIVE_W     = 13;
  localparam int ANGLE_W     = 16;
  localparam int ANGLE_MAG_W = 15;
  localparam int APB_DATA_W  = 32;
  localparam int REG_ADDR_W  = 4;

  localparam int QUARTER_TURN = 23040;
  localparam int DRIVE_MAX    = 4094;

  localparam longint unsigned PI_Q34    = 64'hC90FDAA22;
  localparam longint unsigned THETA_DIV = 64'd737280;

  localparam logic [1:0] REG_GAIN_MOVING  = 2'd0;
  localparam logic [1:0] REG_GAIN_STOPPED = 2'd1;
  localparam logic [1:0] REG_DRIVE_LIMIT  = 2'd2;
  localparam logic [1:0] REG_WHEELBASE    = 2'd3;

  localparam logic [GAIN_W-1:0]  GAIN_MOVING_RST  = 12'd1000;
  localparam logic [GAIN_W-1:0]  GAIN_STOPPED_RST = 12'd1500;
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST  = 12'd1200;
  localparam logic [WBASE_W-1:0] WHEELBASE_RST    = 15'd4895;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_moving;
    logic [GAIN_W-1:0]  gain_stopped;
    logic [LIMIT_W-1:0] drive_limit;
    logic [WBASE_W-1:0] wheelbase;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic check;
    logic step;
    logic look;
    logic finish;
  } dp_cmd_t;

  // sine of a/256 degrees in Q30, series through x^15
  function automatic longint sin_q30(longint unsigned a);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x    = (a * PI_Q34) / THETA_DIV;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - longint'(term);
    return sum;
  endfunction

endpackage

>>> rtl/sia_ifs.sv
// ----------------------------------------------------------------------------
// sia_demand_if / sia_result_if
// Valid/ready channels carrying one demand item and one result item.
// ----------------------------------------------------------------------------
interface sia_demand_if;
  import sia_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] target_speed;
  logic signed [SPEED_W-1:0] target_yaw_rate;
  logic signed [SPEED_W-1:0] measured_speed;
  logic signed [SPEED_W-1:0] wheel_speed;

  modport source (
    output valid, target_speed, target_yaw_rate, measured_speed, wheel_speed,
    input  ready
  );
  modport sink (
    input  valid, target_speed, target_yaw_rate, measured_speed, wheel_speed,
    output ready
  );
endinterface

interface sia_result_if;
  import sia_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_command;
  logic signed [ANGLE_W-1:0] steering_angle;

  modport source (
    output valid, drive_command, steering_angle,
    input  ready
  );
  modport sink (
    input  valid, drive_command, steering_angle,
    output ready
  );
endinterface

>>> rtl/sia_regs.sv
// ----------------------------------------------------------------------------
// sia_regs
// APB register file: gains, drive limit and wheelbase.
// ----------------------------------------------------------------------------
module sia_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sia_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [sia_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sia_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output sia_pkg::cfg_t                    cfg
);
  import sia_pkg::*;

  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_moving  <= GAIN_MOVING_RST;
      cfg.gain_stopped <= GAIN_STOPPED_RST;
      cfg.drive_limit  <= DRIVE_LIMIT_RST;
      cfg.wheelbase    <= WHEELBASE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_MOVING:  cfg.gain_moving  <= pwdata[GAIN_W-1:0];
        REG_GAIN_STOPPED: cfg.gain_stopped <= pwdata[GAIN_W-1:0];
        REG_DRIVE_LIMIT:  cfg.drive_limit  <= pwdata[LIMIT_W-1:0];
        REG_WHEELBASE:    cfg.wheelbase    <= pwdata[WBASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_MOVING:  prdata = APB_DATA_W'(cfg.gain_moving);
      REG_GAIN_STOPPED: prdata = APB_DATA_W'(cfg.gain_stopped);
      REG_DRIVE_LIMIT:  prdata = APB_DATA_W'(cfg.drive_limit);
      REG_WHEELBASE:    prdata = APB_DATA_W'(cfg.wheelbase);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> rtl/sia_ctrl.sv
// ----------------------------------------------------------------------------
// sia_ctrl
// Sequencer: accept, multiply, scale, check, quotient steps, lookup, hand-off.
// ----------------------------------------------------------------------------
module sia_ctrl #(
  parameter int ASIN_TABLE_DEPTH = sia_pkg::ASIN_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sia_pkg::dp_cmd_t cmd
);
  import sia_pkg::*;

  localparam int DW    = $clog2(ASIN_TABLE_DEPTH + 1);
  localparam int CNT_W = $clog2(DW);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_LOOK  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             last_step;
  logic             hand_off;

  assign in_ready  = (state == S_IDLE);
  assign last_step = (cnt == CNT_W'(DW - 1));
  assign hand_off  = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.mul    = (state == S_MUL);
    cmd.scale  = (state == S_SCALE);
    cmd.check  = (state == S_CHECK);
    cmd.step   = (state == S_DIV);
    cmd.look   = (state == S_LOOK);
    cmd.finish = hand_off;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL;
      S_MUL:   state_next = S_SCALE;
      S_SCALE: state_next = S_CHECK;
      S_CHECK: state_next = S_DIV;
      S_DIV:   if (last_step) state_next = S_LOOK;
      S_LOOK:  state_next = S_FIN;
      S_FIN:   if (hand_off) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= last_step ? '0 : cnt + 1'b1;
      end
      if (hand_off) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/sia_dp.sv
// ----------------------------------------------------------------------------
// sia_dp
// Datapath: speed integrator with clamp, serial quotient for the arcsine
// index, arcsine table and result registers.
// ----------------------------------------------------------------------------
module sia_dp #(
  parameter int FRAC_BITS        = sia_pkg::FRAC_BITS_DEF,
  parameter int ASIN_TABLE_DEPTH = sia_pkg::ASIN_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sia_pkg::dp_cmd_t                    cmd,
  input  sia_pkg::cfg_t                       cfg,
  input  logic signed [sia_pkg::SPEED_W-1:0]  target_speed,
  input  logic signed [sia_pkg::SPEED_W-1:0]  target_yaw_rate,
  input  logic signed [sia_pkg::SPEED_W-1:0]  measured_speed,
  input  logic signed [sia_pkg::SPEED_W-1:0]  wheel_speed,
  output logic signed [sia_pkg::DRIVE_W-1:0]  drive_command,
  output logic signed [sia_pkg::ANGLE_W-1:0]  steering_angle
);
  import sia_pkg::*;

  localparam int IW  = FRAC_BITS + 14;
  localparam int PW  = GAIN_W + SPEED_W + 2;
  localparam int SW  = ((IW > PW) ? IW : PW) + 1;
  localparam int MW  = SPEED_W + WBASE_W;
  localparam int DW  = $clog2(ASIN_TABLE_DEPTH + 1);
  localparam int AW  = $clog2(ASIN_TABLE_DEPTH);
  localparam int NW  = 32 + DW;
  localparam int HW  = NW - DW;
  localparam int DDW = FRAC_BITS + 17;
  localparam int CW  = (HW > DDW) ? HW : DDW;

  function automatic logic [ANGLE_MAG_W-1:0] asin_entry(int unsigned k);
    longint          target;
    longint          above;
    longint          below;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo     = 0;
    hi     = longint'(QUARTER_TURN);
    target = longint'((longint'(k) << 30) / ASIN_TABLE_DEPTH);
    for (int i = 0; i < 16; i++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (sin_q30(mid) >= target) hi = mid;
        else lo = mid + 1;
      end
    end
    if (lo > 0) begin
      above = sin_q30(lo) - target;
      below = target - sin_q30(lo - 1);
      if (below < above) lo = lo - 1;
    end
    return ANGLE_MAG_W'(lo);
  endfunction

  logic [ANGLE_MAG_W-1:0] asin_rom [ASIN_TABLE_DEPTH];

  for (genvar g = 0; g < ASIN_TABLE_DEPTH; g++) begin : g_rom
    assign asin_rom[g] = asin_entry(g);
  end

  logic signed [SPEED_W-1:0] vt;
  logic signed [SPEED_W-1:0] yaw;
  logic signed [SPEED_W-1:0] vm;
  logic signed [SPEED_W-1:0] vw;
  logic signed [PW-1:0]      gprod;
  logic [MW-1:0]             prod;
  logic [SPEED_W-1:0]        aw;
  logic                      neg;
  logic                      zero;
  logic signed [IW-1:0]      integ;
  logic [NW-1:0]             numer;
  logic [DDW-1:0]            denom;
  logic [DDW-1:0]            rem;
  logic [DW-1:0]             qn;
  logic                      sat;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [ANGLE_W-1:0] angle;

  // multiply stage
  logic signed [SPEED_W:0] err;
  logic [GAIN_W-1:0]       gain;
  logic [SPEED_W-1:0]      ay;
  logic [SPEED_W-1:0]      aw_in;

  assign err   = (SPEED_W + 1)'(vt) - (SPEED_W + 1)'(vm);
  assign gain  = (vt != '0) ? cfg.gain_moving : cfg.gain_stopped;
  assign ay    = yaw[SPEED_W-1] ? $unsigned(-yaw) : $unsigned(yaw);
  assign aw_in = vw[SPEED_W-1] ? $unsigned(-vw) : $unsigned(vw);

  // integrator and clamp
  logic [LIMIT_W-1:0]   lim;
  logic signed [SW-1:0] bound;
  logic signed [SW-1:0] held;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] integ_next;

  assign lim   = (cfg.drive_limit == '0) ? LIMIT_W'(1) : cfg.drive_limit;
  assign bound = $signed(SW'({lim, {FRAC_BITS{1'b0}}}));
  assign held  = $signed(SW'({LIMIT_W'(lim - 1'b1), {FRAC_BITS{1'b0}}}));
  assign sum   = SW'(integ) + SW'(gprod);

  always_comb begin
    if (sum >= bound) begin
      integ_next = held;
    end else if (sum <= -bound) begin
      integ_next = -held;
    end else begin
      integ_next = sum;
    end
  end

  logic [IW-1:0]      integ_abs;
  logic [DRIVE_W-1:0] drive_mag;

  assign integ_abs = integ[IW-1] ? $unsigned(-integ) : $unsigned(integ);
  assign drive_mag = DRIVE_W'(integ_abs >> FRAC_BITS);

  // quotient
  logic [HW-1:0]  numer_hi;
  logic [DDW:0]   shifted;
  logic [DDW:0]   diff;
  logic           fits;

  assign numer_hi = numer[NW-1:DW];
  assign shifted  = {rem, qn[DW-1]};
  assign fits     = shifted >= {1'b0, denom};
  assign diff     = shifted - {1'b0, denom};

  // lookup
  logic                   top;
  logic [ANGLE_MAG_W-1:0] mag;

  assign top = sat || (qn >= DW'(ASIN_TABLE_DEPTH));
  assign mag = top ? ANGLE_MAG_W'(QUARTER_TURN) : asin_rom[qn[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
    end else if (cmd.scale) begin
      integ <= IW'(integ_next);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vt  <= target_speed;
      yaw <= target_yaw_rate;
      vm  <= measured_speed;
      vw  <= wheel_speed;
    end
    if (cmd.mul) begin
      gprod <= $signed({1'b0, gain}) * err;
      prod  <= MW'(ay) * MW'(cfg.wheelbase);
      aw    <= aw_in;
      neg   <= yaw[SPEED_W-1] ^ vw[SPEED_W-1];
      zero  <= (vw == '0);
    end
    if (cmd.scale) begin
      numer <= ((NW'(prod) * NW'(ASIN_TABLE_DEPTH)) << 1) + (NW'(aw) << FRAC_BITS);
      denom <= DDW'(aw) << (FRAC_BITS + 1);
    end
    if (cmd.check) begin
      sat   <= CW'(numer_hi) >= CW'(denom);
      rem   <= DDW'(numer_hi);
      qn    <= numer[DW-1:0];
      drive <= integ[IW-1] ? -$signed(drive_mag) : $signed(drive_mag);
    end
    if (cmd.step) begin
      rem <= fits ? DDW'(diff) : DDW'(shifted);
      qn  <= {qn[DW-2:0], fits};
    end
    if (cmd.look) begin
      if (zero) begin
        angle <= '0;
      end else if (neg) begin
        angle <= -$signed(ANGLE_W'(mag));
      end else begin
        angle <= $signed(ANGLE_W'(mag));
      end
    end
    if (cmd.finish) begin
      drive_command  <= drive;
      steering_angle <= angle;
    end
  end

endmodule

>>> rtl/speed_integral_and_steer_angle.sv
// ----------------------------------------------------------------------------
// speed_integral_and_steer_angle
// Integral drive command from the speed error and bicycle-model steering
// angle, one result item per demand item.
// ----------------------------------------------------------------------------
// The bit-serial quotient unit that forms the arcsine table index produces one
// bit per cycle. One item is worked on at a time; the result sits in an output
// register, so the next item is taken while it waits. The drive command is the
// integrator truncated toward zero after the clamp to plus or minus
// (drive_limit - 1); a drive_limit of 0 acts as 1. The steering angle is 0 for
// zero wheel speed. Registers are written over APB at byte addresses 0, 4, 8
// and 12 (gain_moving, gain_stopped, drive_limit, wheelbase); the user must
// write them only while the block is idle, which the block does not enforce.
// Reset clears the integrator.
module speed_integral_and_steer_angle #(
  parameter int FRAC_BITS        = sia_pkg::FRAC_BITS_DEF,
  parameter int ASIN_TABLE_DEPTH = sia_pkg::ASIN_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sia_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [sia_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sia_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  sia_demand_if.sink                     demand,
  sia_result_if.source                   result
);
  import sia_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;

  sia_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sia_ctrl #(
    .ASIN_TABLE_DEPTH (ASIN_TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (demand.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  sia_dp #(
    .FRAC_BITS        (FRAC_BITS),
    .ASIN_TABLE_DEPTH (ASIN_TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg             (cfg),
    .target_speed    (demand.target_speed),
    .target_yaw_rate (demand.target_yaw_rate),
    .measured_speed  (demand.measured_speed),
    .wheel_speed     (demand.wheel_speed),
    .drive_command   (result.drive_command),
    .steering_angle  (result.steering_angle)
  );

  assign demand.ready = in_ready;
  assign result.valid = out_valid;

endmodule

>>> rtl/sia_checker.sv
// ----------------------------------------------------------------------------
// sia_checker
// Port-level checks for the speed integrator and steering angle block.
// ----------------------------------------------------------------------------
module sia_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [sia_pkg::DRIVE_W-1:0] drive_command,
  input logic signed [sia_pkg::ANGLE_W-1:0] steering_angle
);
  import sia_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // one item in work at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("demand taken while an item is in work");

  // lower bound on the time from an accepted item to a rising out_valid
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result too soon after item");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (steering_angle <= QUARTER_TURN && steering_angle >= -QUARTER_TURN))
    else $error("steering angle out of range");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_command <= DRIVE_MAX && drive_command >= -DRIVE_MAX))
    else $error("drive command out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_command)
      && $stable(steering_angle))
    else $error("stalled result changed");

endmodule

bind speed_integral_and_steer_angle sia_checker u_sia_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (demand.valid),
  .in_ready       (demand.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .drive_command  (result.drive_command),
  .steering_angle (result.steering_angle)
);

>>> sim/speed_integral_and_steer_angle_tb.sv
// ----------------------------------------------------------------------------
// speed_integral_and_steer_angle_tb
// Self-checking bench for the speed integrator and steering angle block.
// Demand items come from a queue through a randomly gapped valid/ready driver.
// Each accepted item runs through a local model of the integrator and the
// arcsine lookup, and the outcome is queued. A monitor with random back
// pressure pops the queue and compares it with every result item. Registers
// are reprogrammed over APB between phases, and every write waits until the
// block has drained.
// ----------------------------------------------------------------------------
module speed_integral_and_steer_angle_tb;
  import sia_pkg::*;

  localparam int FRAC = 12;
  localparam longint unsigned LUT_DEPTH = 256;
  localparam longint ANGLE_MAX = 23040;
  localparam longint unsigned PI_SCALED = 64'hC90FDAA22;
  localparam longint unsigned CODE_TO_RAD_DIV = 64'd737280;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 40;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct {
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [SPEED_W-1:0] target_yaw_rate;
    logic signed [SPEED_W-1:0] measured_speed;
    logic signed [SPEED_W-1:0] wheel_speed;
  } demand_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive_command;
    logic signed [ANGLE_W-1:0] steering_angle;
  } steer_drive_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sia_demand_if demand_ch ();
  sia_result_if result_ch ();

  speed_integral_and_steer_angle u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .demand  (demand_ch),
    .result  (result_ch)
  );

  // register shadows and integrator
  longint gain_moving_q  = 1000;
  longint gain_stopped_q = 1500;
  longint drive_limit_q  = 1200;
  longint wheelbase_q    = 4895;
  longint drive_integral = 0;

  longint       asin_lut [0:LUT_DEPTH];
  demand_t      pending_demands [$];
  steer_drive_t predicted_results [$];
  demand_t      offered;
  steer_drive_t want;

  int   tx_gap = 0;
  int   rx_gap = 0;
  bit   tx_idle_on = 1'b0;
  bit   rx_idle_on = 1'b0;
  bit   long_hold_go = 1'b0;
  logic rx_hold = 1'b0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  always #5 clk = ~clk;

  function automatic longint sine_of_code(longint unsigned code);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned n;
    longint acc;
    x = (code * PI_SCALED) / CODE_TO_RAD_DIV;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n[0]) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return acc;
  endfunction

  function automatic longint asin_of_index(longint unsigned k);
    longint goal;
    longint above;
    longint below;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (k >= LUT_DEPTH) return ANGLE_MAX;
    goal = longint'((k << 30) / LUT_DEPTH);
    lo = 0;
    hi = ANGLE_MAX;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (sine_of_code(mid) >= goal) hi = mid;
      else lo = mid + 1;
    end
    if (lo > 0) begin
      above = sine_of_code(lo) - goal;
      below = goal - sine_of_code(lo - 1);
      if (below < above) lo = lo - 1;
    end
    return longint'(lo);
  endfunction

  function automatic void integrate_and_steer(input demand_t d);
    longint vt, yaw, vm, vw;
    longint gain, lim, bound, held, acc, cmd, angle;
    longint unsigned ay, aw, num, den, k;
    steer_drive_t r;
    vt = d.target_speed;
    yaw = d.target_yaw_rate;
    vm = d.measured_speed;
    vw = d.wheel_speed;
    gain = (vt != 0) ? gain_moving_q : gain_stopped_q;
    lim = (drive_limit_q == 0) ? 1 : drive_limit_q;
    bound = lim <<< FRAC;
    held = (lim - 1) <<< FRAC;
    acc = drive_integral + gain * (vt - vm);
    if (acc >= bound) acc = held;
    else if (acc <= -bound) acc = -held;
    drive_integral = acc;
    cmd = (acc < 0) ? -((-acc) >>> FRAC) : (acc >>> FRAC);
    angle = 0;
    if (vw != 0) begin
      ay = (yaw < 0) ? -yaw : yaw;
      aw = (vw < 0) ? -vw : vw;
      num = ay * longint'(wheelbase_q) * LUT_DEPTH;
      den = aw << FRAC;
      k = (2 * num + den) / (2 * den);
      if (k > LUT_DEPTH) k = LUT_DEPTH;
      angle = asin_lut[k];
      if ((yaw < 0) != (vw < 0)) angle = -angle;
    end
    r.drive_command = DRIVE_W'(cmd);
    r.steering_angle = ANGLE_W'(angle);
    predicted_results.push_back(r);
  endfunction

  function automatic void queue_demand(input int vt, input int yaw, input int vm,
                                       input int vw);
    demand_t d;
    d.target_speed = vt[SPEED_W-1:0];
    d.target_yaw_rate = yaw[SPEED_W-1:0];
    d.measured_speed = vm[SPEED_W-1:0];
    d.wheel_speed = vw[SPEED_W-1:0];
    pending_demands.push_back(d);
  endfunction

  function automatic int unsigned pick_setting(input int unsigned lo_v, input int unsigned hi_v,
                                               input int w);
    int unsigned v;
    case ($urandom_range(0, 5))
      0: v = lo_v;
      1: v = hi_v;
      default: v = $urandom_range(lo_v, hi_v);
    endcase
    // junk above the register width must be dropped
    if ($urandom_range(0, 3) == 0) v = v | ($urandom << w);
    return v;
  endfunction

  function automatic void log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0d: %s", cycle_count, what);
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAIN_MOVING:  gain_moving_q = value[GAIN_W-1:0];
      REG_GAIN_STOPPED: gain_stopped_q = value[GAIN_W-1:0];
      REG_DRIVE_LIMIT:  drive_limit_q = value[LIMIT_W-1:0];
      REG_WHEELBASE:    wheelbase_q = value[WBASE_W-1:0];
      default: ;
    endcase
  endtask

  // sampled mid-cycle, once the driver and monitor have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_demands.size() != 0 || demand_ch.valid || predicted_results.size() != 0)
      @(negedge clk);
  endtask

  // demand driver
  always @(posedge clk) begin
    if (rst) begin
      demand_ch.valid <= 1'b0;
    end else begin
      if (demand_ch.valid && demand_ch.ready) integrate_and_steer(offered);
      if (!demand_ch.valid || demand_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          demand_ch.valid <= 1'b0;
        end else if (pending_demands.size() != 0) begin
          offered = pending_demands.pop_front();
          demand_ch.target_speed <= offered.target_speed;
          demand_ch.target_yaw_rate <= offered.target_yaw_rate;
          demand_ch.measured_speed <= offered.measured_speed;
          demand_ch.wheel_speed <= offered.wheel_speed;
          demand_ch.valid <= 1'b1;
          tx_gap = tx_idle_on ? $urandom_range(0, 6) : 0;
        end else begin
          demand_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_results.size() == 0) begin
          log_mismatch($sformatf("unexpected item drive %0d angle %0d",
                                 result_ch.drive_command, result_ch.steering_angle));
        end else begin
          want = predicted_results.pop_front();
          if (result_ch.drive_command !== want.drive_command)
            log_mismatch($sformatf("drive_command exp %0d got %0d",
                                   want.drive_command, result_ch.drive_command));
          if (result_ch.steering_angle !== want.steering_angle)
            log_mismatch($sformatf("steering_angle exp %0d got %0d",
                                   want.steering_angle, result_ch.steering_angle));
        end
        rx_gap = rx_idle_on ? $urandom_range(0, 6) : 0;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      result_ch.ready <= !rx_hold && rx_gap == 0;
    end
  end

  // long receiver hold
  initial begin
    wait (long_hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int i;
    int p;
    int n;
    int vt, yaw, vm, vw, aw, cap;
    demand_ch.valid = 1'b0;
    demand_ch.target_speed = '0;
    demand_ch.target_yaw_rate = '0;
    demand_ch.measured_speed = '0;
    demand_ch.wheel_speed = '0;
    result_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (i = 0; i <= LUT_DEPTH; i++) asin_lut[i] = asin_of_index(i);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings
    queue_demand(0, 0, 0, 0);
    queue_demand(32767, 32767, -32768, 1);
    queue_demand(-32768, -32768, 32767, 1);
    queue_demand(0, 0, 300, -5);
    queue_demand(1000, 100, 1000, -32768);
    queue_demand(-1, -100, -1, -32768);
    queue_demand(0, 32767, 0, 32767);
    queue_demand(4096, 1000, 2048, 4096);
    queue_demand(-4096, -32768, -4096, -32767);
    queue_demand(0, 1, -1, 1);
    wait_idle();

    // limit of zero acts as one, widest wheelbase
    reg_write(REG_GAIN_MOVING, 32'd4095);
    reg_write(REG_GAIN_STOPPED, 32'd1);
    reg_write(REG_DRIVE_LIMIT, 32'hFFFF_F000);
    reg_write(REG_WHEELBASE, 32'd32767);
    queue_demand(1, 0, 0, 0);
    queue_demand(1, 0, 0, 0);
    queue_demand(0, 0, 1, 0);
    queue_demand(0, -32768, 0, -32768);
    queue_demand(0, 1, 0, 32767);
    queue_demand(100, 200, -100, -3);
    wait_idle();

    // truncation toward zero for a small negative sum
    reg_write(REG_DRIVE_LIMIT, 32'd1200);
    queue_demand(0, 0, 1, 7);
    wait_idle();

    reg_write(REG_GAIN_MOVING, 32'd0);
    reg_write(REG_GAIN_STOPPED, 32'd4095);
    reg_write(REG_DRIVE_LIMIT, 32'd4095);
    reg_write(REG_WHEELBASE, 32'd0);
    queue_demand(5, 32767, -5, 1);
    queue_demand(0, 0, 32767, 100);
    queue_demand(0, 0, -32768, 100);
    queue_demand(0, 0, -32768, 100);
    queue_demand(-32768, 0, -32768, -1);
    wait_idle();

    for (p = 0; p < RAND_PHASES; p++) begin
      reg_write(REG_GAIN_MOVING, pick_setting(0, 4095, GAIN_W));
      reg_write(REG_GAIN_STOPPED, pick_setting(0, 4095, GAIN_W));
      reg_write(REG_DRIVE_LIMIT, pick_setting(1, 4095, LIMIT_W));
      reg_write(REG_WHEELBASE, pick_setting(0, 32767, WBASE_W));
      tx_idle_on = (p % 3) != 0;
      rx_idle_on = (p % 3) != 1;
      if (p == 4) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        long_hold_go = 1'b1;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 3))
          0: vt = 0;
          1: vt = $urandom_range(0, 65535);
          default: vt = int'($urandom_range(0, 4000)) - 2000;
        endcase
        if ($urandom_range(0, 3) == 0) vm = $urandom_range(0, 65535);
        else vm = vt + int'($urandom_range(0, 600)) - 300;
        case ($urandom_range(0, 9))
          0: vw = 0;
          1: vw = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
          2: vw = ($urandom_range(0, 1) != 0) ? -1 : 1;
          default: vw = int'(signed'(16'($urandom_range(0, 65535))));
        endcase
        if ($urandom_range(0, 1) == 0) begin
          yaw = $urandom_range(0, 65535);
        end else begin
          // keep the arcsine argument mostly below one
          aw = (vw < 0) ? -vw : vw;
          cap = (wheelbase_q == 0) ? 32767 : int'((longint'(aw) * 4096) / wheelbase_q);
          if (cap > 32767) cap = 32767;
          yaw = $urandom_range(0, cap);
          if ($urandom_range(0, 1) != 0) yaw = -yaw;
        end
        queue_demand(vt, yaw, vm, vw);
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sia_pkg.sv
rtl/sia_ifs.sv
rtl/sia_regs.sv
rtl/sia_ctrl.sv
rtl/sia_dp.sv
rtl/speed_integral_and_steer_angle.sv
rtl/sia_checker.sv
sim/speed_integral_and_steer_angle_tb.sv
